[src/hmtp_pkg.sv]
// Shared types and constants for the height map token parser.
// No dependencies; used by every module in src.
`timescale 1ns / 1ps
`default_nettype none

package hmtp_pkg;

    // Field widths
    localparam int COORD_BITS  = 12;
    localparam int HEIGHT_BITS = 16;
    localparam int BYTE_BITS   = 8;
    localparam int CHAN_BITS   = 8;

    // Result payload packing on the master side
    localparam int DATA_BITS  = 2 * COORD_BITS + HEIGHT_BITS + 3 * CHAN_BITS;
    localparam int TDATA_BITS = ((DATA_BITS + 7) / 8) * 8;
    localparam int TUSER_BITS = 2;

    // One parsed token
    typedef struct packed {
        logic [COORD_BITS-1:0]         column;
        logic [COORD_BITS-1:0]         row;
        logic signed [HEIGHT_BITS-1:0] height;
        logic [CHAN_BITS-1:0]          red;
        logic [CHAN_BITS-1:0]          green;
        logic [CHAN_BITS-1:0]          blue;
        logic                          color_given;
        logic                          format_error;
    } t_result;

endpackage

`default_nettype wire

[src/heightmap_token_parser.sv]
// Height map token parser: one text byte in per cycle, one token out when it closes.
// A closing byte (space, newline or end of input) waits in the input register once
// accepted, then parses straight into the result register.
// Throughput: one byte per cycle; a stall happens only when a result is due while the
// result register is still held by the master side.
// Reset (i_rst_n low, synchronous): counters zero, parser between tokens, both
// stages empty.
// Depends on hmtp_pkg, hmtp_in_stage, hmtp_core, hmtp_out_stage.
`timescale 1ns / 1ps
`default_nettype none

module heightmap_token_parser (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Slave side: one character request
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [hmtp_pkg::BYTE_BITS-1:0]   s_axis_tdata,  // [7:0] byte_req
    input  wire logic                             s_axis_tlast,  // end_of_input
    // Master side: one token
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // column, row, height, red, green, blue from bit 0 up, zero padded
    output logic [hmtp_pkg::TDATA_BITS-1:0]       m_axis_tdata,
    // [0] color_given, [1] format_error
    output logic [hmtp_pkg::TUSER_BITS-1:0]       m_axis_tuser
);

    logic                          in_valid;
    logic [hmtp_pkg::BYTE_BITS-1:0] in_byte;
    logic                          in_last;
    logic                          fire;
    logic                          emit;
    logic                          out_free;
    hmtp_pkg::t_result             core_result;
    hmtp_pkg::t_result             out_result;

    // Consume the held byte unless it closes a token and the result slot is busy
    assign fire = in_valid && (!emit || out_free);

    hmtp_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_s_byte  (s_axis_tdata),
        .i_s_last  (s_axis_tlast),
        .i_take    (fire),
        .o_valid   (in_valid),
        .o_byte    (in_byte),
        .o_last    (in_last)
    );

    hmtp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_byte   (in_byte),
        .i_last   (in_last),
        .o_emit   (emit),
        .o_result (core_result)
    );

    hmtp_out_stage u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (fire && emit),
        .i_result  (core_result),
        .o_free    (out_free),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_result  (out_result)
    );

    // Pack the result fields, first field in the lowest bits
    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[hmtp_pkg::DATA_BITS-1:0] = {
            out_result.blue,
            out_result.green,
            out_result.red,
            out_result.height,
            out_result.row,
            out_result.column
        };
    end

    assign m_axis_tuser = {out_result.format_error, out_result.color_given};

endmodule

`default_nettype wire

[src/hmtp_in_stage.sv]
// Input register for the character stream: holds one byte request.
// Depends on hmtp_pkg for the byte width.
`timescale 1ns / 1ps
`default_nettype none

module hmtp_in_stage (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_valid,
    output logic                               o_s_ready,
    input  wire logic [hmtp_pkg::BYTE_BITS-1:0] i_s_byte,
    input  wire logic                          i_s_last,
    input  wire logic                          i_take,
    output logic                               o_valid,
    output logic [hmtp_pkg::BYTE_BITS-1:0]     o_byte,
    output logic                               o_last
);

    logic                          r_valid;
    logic [hmtp_pkg::BYTE_BITS-1:0] r_byte;
    logic                          r_last;

    // Free when empty or when the held request is consumed this cycle
    assign o_s_ready = !r_valid || i_take;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_ready) begin
            r_valid <= i_s_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (o_s_ready && i_s_valid) begin
            r_byte <= i_s_byte;
            r_last <= i_s_last;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule

`default_nettype wire

[src/hmtp_core.sv]
// Token parser state machine: counters, accumulators and result formatting.
// Depends on hmtp_pkg for widths and the t_result type.
`timescale 1ns / 1ps
`default_nettype none

module hmtp_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_fire,
    input  wire logic [hmtp_pkg::BYTE_BITS-1:0] i_byte,
    input  wire logic                          i_last,
    output logic                               o_emit,
    output hmtp_pkg::t_result                  o_result
);

    localparam int CB = hmtp_pkg::COORD_BITS;
    localparam int HB = hmtp_pkg::HEIGHT_BITS;
    localparam int SB = HB + 4;     // width of mag * 10 + digit

    localparam logic [HB-1:0] LIM     = HB'(1) << (HB - 1);
    localparam logic [HB-1:0] POS_MAX = LIM - HB'(1);

    // Character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;
    localparam logic [7:0] OFS_DIG  = 8'd48;
    localparam logic [7:0] OFS_UP   = 8'd55;
    localparam logic [7:0] OFS_LOW  = 8'd87;

    localparam logic [2:0] HEX_FULL = 3'd6;
    localparam logic [2:0] HEX_OVER = 3'd7;
    localparam logic [2:0] HEX_MID  = 3'd4;
    localparam logic [2:0] HEX_LOW  = 3'd2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_DIG,
        PH_TAIL,
        PH_SKIP1,
        PH_SKIP2,
        PH_HEX
    } t_phase;

    t_phase         r_phase, n_phase;
    logic [CB-1:0]  r_col, n_col;
    logic [CB-1:0]  r_row, n_row;
    logic [HB-1:0]  r_mag, n_mag;
    logic           r_neg, n_neg;
    logic [23:0]    r_color, n_color;
    logic [2:0]     r_hex_cnt, n_hex_cnt;
    logic           r_err, n_err;

    // Hex decode: bit 4 flags a valid digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= CH_0 && c <= CH_9) begin
            v = c - OFS_DIG;
            return {1'b1, v[3:0]};
        end else if (c >= CH_UA && c <= CH_UF) begin
            v = c - OFS_UP;
            return {1'b1, v[3:0]};
        end else if (c >= CH_LA && c <= CH_LF_HEX) begin
            v = c - OFS_LOW;
            return {1'b1, v[3:0]};
        end
        return 5'd0;
    endfunction

    logic           is_digit;
    logic [3:0]     digit;
    logic [SB-1:0]  dec_sum;
    logic [4:0]     hex;
    logic           token_open;
    logic [CB-1:0]  col_inc;
    logic [CB-1:0]  row_inc;

    assign is_digit   = (i_byte >= CH_0) && (i_byte <= CH_9);
    assign digit      = i_byte[3:0];
    assign hex        = hex_decode(i_byte);
    assign token_open = (r_phase != PH_IDLE);
    assign col_inc    = (&r_col) ? r_col : r_col + CB'(1);
    assign row_inc    = (&r_row) ? r_row : r_row + CB'(1);
    // mag * 10 + digit as 8 * mag + 2 * mag + digit
    assign dec_sum    = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0} + SB'(digit);

    // Result formatting from the current token state
    logic [HB-1:0] mag_out;
    logic [23:0]   col_val;
    logic [2:0]    col_n;
    logic          err_out;
    always_comb begin
        mag_out = r_mag;
        err_out = r_err;
        if (!r_neg && r_mag >= LIM) begin
            mag_out = POS_MAX;
            err_out = 1'b1;
        end
        col_val = r_color;
        col_n   = r_hex_cnt;
        if (r_hex_cnt == HEX_OVER) begin
            col_n = HEX_FULL;
        end else if (r_hex_cnt[0]) begin
            col_val = r_color >> 4;
            col_n   = r_hex_cnt - 3'd1;
        end
        o_result.column = r_col;
        o_result.row    = r_row;
        o_result.height = r_neg ? (HB'(0) - mag_out) : mag_out;
        if (r_phase == PH_SKIP1 || r_phase == PH_SKIP2 || r_phase == PH_HEX) begin
            o_result.color_given  = 1'b1;
            o_result.format_error = err_out || (r_hex_cnt == HEX_OVER);
            o_result.red   = (col_n == HEX_FULL) ? col_val[23:16] : 8'd0;
            o_result.green = (col_n >= HEX_MID)  ? col_val[15:8]  : 8'd0;
            o_result.blue  = (col_n >= HEX_LOW)  ? col_val[7:0]   : 8'd0;
        end else begin
            o_result.color_given  = 1'b0;
            o_result.format_error = err_out;
            o_result.red   = 8'hFF;
            o_result.green = 8'hFF;
            o_result.blue  = 8'hFF;
        end
    end

    // Next state for one character
    always_comb begin
        n_phase   = r_phase;
        n_col     = r_col;
        n_row     = r_row;
        n_mag     = r_mag;
        n_neg     = r_neg;
        n_color   = r_color;
        n_hex_cnt = r_hex_cnt;
        n_err     = r_err;
        o_emit    = 1'b0;
        if (i_last) begin
            // End of file: flush and return to reset
            o_emit    = token_open;
            n_phase   = PH_IDLE;
            n_col     = '0;
            n_row     = '0;
            n_mag     = '0;
            n_neg     = 1'b0;
            n_color   = '0;
            n_hex_cnt = '0;
            n_err     = 1'b0;
        end else if (i_byte == CH_SPACE || i_byte == CH_LF) begin
            o_emit = token_open;
            if (token_open) begin
                n_phase   = PH_IDLE;
                n_mag     = '0;
                n_neg     = 1'b0;
                n_color   = '0;
                n_hex_cnt = '0;
                n_err     = 1'b0;
                n_col     = col_inc;
            end
            if (i_byte == CH_LF) begin
                n_col = '0;
                n_row = row_inc;
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                    n_mag     = '0;
                    n_neg     = 1'b0;
                    n_color   = '0;
                    n_hex_cnt = '0;
                    n_err     = 1'b0;
                    if (i_byte == CH_MINUS) begin
                        n_neg   = 1'b1;
                        n_phase = PH_DIG;
                    end else if (i_byte == CH_PLUS) begin
                        n_phase = PH_DIG;
                    end else if (is_digit) begin
                        n_mag   = HB'(digit);
                        n_phase = PH_DIG;
                    end else if (i_byte == CH_COMMA) begin
                        n_phase = PH_SKIP1;
                    end else begin
                        n_phase = PH_TAIL;
                    end
                end
                PH_DIG: begin
                    if (is_digit) begin
                        // Magnitude saturates at 2^(HB-1)
                        if (dec_sum > SB'(LIM)) begin
                            n_mag = LIM;
                            n_err = 1'b1;
                        end else begin
                            n_mag = dec_sum[HB-1:0];
                        end
                    end else if (i_byte == CH_COMMA) begin
                        n_phase = PH_SKIP1;
                    end else begin
                        n_phase = PH_TAIL;
                    end
                end
                PH_TAIL: begin
                    if (i_byte == CH_COMMA) begin
                        n_phase = PH_SKIP1;
                    end
                end
                PH_SKIP1: n_phase = PH_SKIP2;
                PH_SKIP2: n_phase = PH_HEX;
                PH_HEX: begin
                    if (hex[4]) begin
                        if (r_hex_cnt < HEX_FULL) begin
                            n_color = {r_color[19:0], hex[3:0]};
                        end
                        if (r_hex_cnt < HEX_OVER) begin
                            n_hex_cnt = r_hex_cnt + 3'd1;
                        end
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // State registers, advanced once per consumed character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_col     <= '0;
            r_row     <= '0;
            r_mag     <= '0;
            r_neg     <= 1'b0;
            r_color   <= '0;
            r_hex_cnt <= '0;
            r_err     <= 1'b0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_col     <= n_col;
            r_row     <= n_row;
            r_mag     <= n_mag;
            r_neg     <= n_neg;
            r_color   <= n_color;
            r_hex_cnt <= n_hex_cnt;
            r_err     <= n_err;
        end
    end

endmodule

`default_nettype wire

[src/hmtp_out_stage.sv]
// Result register on the master side; holds one token until taken.
// Depends on hmtp_pkg for the t_result type.
`timescale 1ns / 1ps
`default_nettype none

module hmtp_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire hmtp_pkg::t_result i_result,
    output logic                   o_free,
    output logic                   o_m_valid,
    input  wire logic              i_m_ready,
    output hmtp_pkg::t_result      o_result
);

    logic              r_valid;
    hmtp_pkg::t_result r_result;

    // Can load when empty or the held result leaves this cycle
    assign o_free = !r_valid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

    assign o_m_valid = r_valid;
    assign o_result  = r_result;

endmodule

`default_nettype wire
